[hw/rtl/mhpq_pkg.sv]
// ============================================================================
// mhpq_pkg - shared types for the max-heap priority queue
// Heap entry layout, level tokens, write-back requests, op and status codes.
// ============================================================================
`default_nettype none

package mhpq_pkg;

    // one heap entry, key in the top bits
    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  tiebreak;
        logic [15:0] payload;
    } entry_t;

    // token handed from one level cell to the next
    typedef struct packed {
        logic   valid;
        logic   is_remove;
        logic   displace;
        entry_t carried;
    } token_t;

    // write request from a level cell back into the level above
    typedef struct packed {
        logic   valid;
        entry_t data;
    } upwrite_t;

    localparam token_t   TOKEN_NONE   = '0;
    localparam upwrite_t UPWRITE_NONE = '0;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // stream data widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // larger key wins, smaller tie-break wins on equal keys
    function automatic logic ranks_above(input entry_t a, input entry_t b);
        return (a.key > b.key) || ((a.key == b.key) && (a.tiebreak < b.tiebreak));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mhpq_cell.sv]
// ============================================================================
// mhpq_cell - one heap level
// Holds the entries of one tree level as sibling pairs, compares the token
// entry against them and hands the token on to the next level.
// ============================================================================
`default_nettype none

module mhpq_cell #(
    parameter int LEVEL = 0,
    parameter int ROWS  = 1,
    parameter int CW    = 4,
    parameter int LW    = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [CW-1:0]     count,
    input  wire logic [LW-1:0]     lt,
    input  wire logic              peek_en,
    input  wire logic [CW:0]       peek_node,
    input  wire mhpq_pkg::token_t  tok_in,
    input  wire logic [CW:0]       tok_in_node,
    output mhpq_pkg::token_t       tok_out,
    output logic [CW:0]            tok_out_node,
    input  wire mhpq_pkg::upwrite_t uw_in,
    input  wire logic [CW:0]       uw_in_node,
    output mhpq_pkg::upwrite_t     uw_out,
    output logic [CW:0]            uw_out_node,
    output mhpq_pkg::entry_t       rd_lo,
    output mhpq_pkg::entry_t       rd_hi,
    output logic                   done
);
    import mhpq_pkg::*;

    localparam int NW = CW + 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [NW-1:0] OFF_MASK = NW'((1 << LEVEL) - 1);
    localparam logic [LW-1:0] LEVEL_L  = LW'(LEVEL);

    // row of a node inside this level
    function automatic logic [RW-1:0] node_row(input logic [NW-1:0] node);
        logic [NW-1:0] off;
        off = (node & OFF_MASK) >> 1;
        return off[RW-1:0];
    endfunction

    // which half of the sibling pair a node sits in
    function automatic logic node_half(input logic [NW-1:0] node);
        return (LEVEL > 0) && node[0];
    endfunction

    entry_t mem_lo [ROWS];
    entry_t mem_hi [ROWS];
    entry_t rd_lo_reg, rd_hi_reg;

    token_t        stg_reg, stg_next;
    logic [NW-1:0] stg_node_reg, stg_node_next;

    logic          rd_en;
    logic [RW-1:0] rd_row;
    logic          wr_en;
    logic [NW-1:0] wr_node;
    entry_t        wr_data;

    logic          own_wr_en;
    logic [NW-1:0] own_wr_node;
    entry_t        own_wr_data;

    logic          ins_last;
    logic [NW-1:0] child_in;
    entry_t        own_e;
    logic          ins_swap;
    logic [LW-1:0] amt;
    logic [CW-1:0] count_sh;
    logic [NW-1:0] cnt_w, c0, c1, cn, gc;
    logic          v0, v1, sel_any, sel_r, leaf;
    entry_t        best;

    // level storage, registered read of one sibling pair
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (node_half(wr_node)) begin
                mem_hi[node_row(wr_node)] <= wr_data;
            end else begin
                mem_lo[node_row(wr_node)] <= wr_data;
            end
        end
        if (rd_en) begin
            rd_lo_reg <= mem_lo[rd_row];
            rd_hi_reg <= mem_hi[rd_row];
        end
    end

    assign rd_lo = rd_lo_reg;
    assign rd_hi = rd_hi_reg;

    // token arrival: an insert at its target level writes at once
    assign ins_last = tok_in.valid && !tok_in.is_remove && (lt == LEVEL_L);
    assign child_in = {tok_in_node[NW-2:0], 1'b0};
    assign rd_en    = (tok_in.valid && !ins_last) || peek_en;

    always_comb begin
        if (tok_in.valid) begin
            rd_row = tok_in.is_remove ? node_row(child_in) : node_row(tok_in_node);
        end else begin
            rd_row = node_row(peek_node);
        end
    end

    always_comb begin
        stg_next       = tok_in;
        stg_next.valid = tok_in.valid && !ins_last;
        stg_node_next  = tok_in_node;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg <= TOKEN_NONE;
        end else begin
            stg_reg <= stg_next;
        end
        stg_node_reg <= stg_node_next;
    end

    // insert compare against the path node
    assign own_e    = node_half(stg_node_reg) ? rd_hi_reg : rd_lo_reg;
    assign ins_swap = stg_reg.displace || ranks_above(stg_reg.carried, own_e);
    assign amt      = lt - LEVEL_L - LW'(1);
    assign count_sh = count >> amt;

    // remove compare against the two children, left first
    assign cnt_w = {1'b0, count};
    assign c0    = {stg_node_reg[NW-2:0], 1'b0};
    assign c1    = {stg_node_reg[NW-2:0], 1'b1};
    assign v0    = (c0 <= cnt_w);
    assign v1    = (c1 <= cnt_w);

    always_comb begin
        best    = stg_reg.carried;
        sel_any = 1'b0;
        sel_r   = 1'b0;
        if (v0 && ranks_above(rd_lo_reg, best)) begin
            best    = rd_lo_reg;
            sel_any = 1'b1;
        end
        if (v1 && ranks_above(rd_hi_reg, best)) begin
            best    = rd_hi_reg;
            sel_any = 1'b1;
            sel_r   = 1'b1;
        end
    end

    assign cn   = sel_r ? c1 : c0;
    assign gc   = {cn[NW-2:0], 1'b0};
    assign leaf = (gc > cnt_w);

    // per-level step
    always_comb begin
        tok_out      = TOKEN_NONE;
        tok_out_node = '0;
        uw_out       = UPWRITE_NONE;
        uw_out_node  = '0;
        own_wr_en    = 1'b0;
        own_wr_node  = tok_in_node;
        own_wr_data  = tok_in.carried;
        done         = 1'b0;
        if (ins_last) begin
            own_wr_en = 1'b1;
            done      = 1'b1;
        end
        if (stg_reg.valid && !stg_reg.is_remove) begin
            if (ins_swap) begin
                own_wr_en   = 1'b1;
                own_wr_node = stg_node_reg;
                own_wr_data = stg_reg.carried;
            end
            tok_out.valid     = 1'b1;
            tok_out.is_remove = 1'b0;
            tok_out.displace  = ins_swap;
            tok_out.carried   = ins_swap ? own_e : stg_reg.carried;
            tok_out_node      = {stg_node_reg[NW-2:0], count_sh[0]};
        end
        if (stg_reg.valid && stg_reg.is_remove) begin
            uw_out.valid = 1'b1;
            uw_out_node  = stg_node_reg;
            if (!sel_any) begin
                uw_out.data = stg_reg.carried;
                done        = 1'b1;
            end else begin
                uw_out.data = best;
                if (leaf) begin
                    own_wr_en   = 1'b1;
                    own_wr_node = cn;
                    own_wr_data = stg_reg.carried;
                    done        = 1'b1;
                end else begin
                    tok_out.valid     = 1'b1;
                    tok_out.is_remove = 1'b1;
                    tok_out.carried   = stg_reg.carried;
                    tok_out_node      = cn;
                end
            end
        end
    end

    // own write or write-back from the level below, never both at once
    always_comb begin
        if (own_wr_en) begin
            wr_en   = 1'b1;
            wr_node = own_wr_node;
            wr_data = own_wr_data;
        end else begin
            wr_en   = uw_in.valid;
            wr_node = uw_in_node;
            wr_data = uw_in.data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/max_heap_priority_queue_core.sv]
// ============================================================================
// max_heap_priority_queue_core - binary max-heap priority queue
// Insert and remove-top requests on a heap held as a chain of level cells.
//
//   channel | dir | tdata fields, lowest bit first
//   s_      | in  | opcode 1, entry_key 8, entry_tiebreak 8, entry_payload 16
//   m_      | out | status 2, top_key 8, top_tiebreak 8, top_payload 16,
//           |     | entry_count 4
//
// An insert walks its token down from the root (level 0) to L, the level
// of the new slot. A remove passes ST_PEEK and ST_FETCH, then compares the
// children on K levels (at least one) in ST_WALK; a remove that empties the
// heap skips the walk. A level reads a sibling pair while the level above
// compares. Rejected requests go straight from ST_IDLE to ST_FIN.
// Reset clears the entry count, the state, the tokens and the output valid;
// the level memories are not cleared.
// A request is taken only when the previous one is finished; a result
// waiting on m_tready holds the next one back in its final cycle.
// ============================================================================
`default_nettype none

module max_heap_priority_queue_core #(
    parameter int CAPACITY = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // opcode[0], entry_key[8:1], entry_tiebreak[16:9], entry_payload[32:17]
    input  wire logic [mhpq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[1:0], top_key[9:2], top_tiebreak[17:10], top_payload[33:18],
    // entry_count[37:34]
    output logic [mhpq_pkg::M_DATA_W-1:0]      m_tdata
);
    import mhpq_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = CW;
    localparam int LW     = $clog2(LEVELS);
    localparam int NW     = CW + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PEEK  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    // level of a 1-based node number
    function automatic logic [LW-1:0] node_level(input logic [CW-1:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < CW; i++) begin
            if (v[i]) begin
                r = LW'(i);
            end
        end
        return r;
    endfunction

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [LW-1:0]   lt_reg, lt_next;
    logic [NW-1:0]   node_reg, node_next;
    token_t          tok_reg, tok_next;
    logic [1:0]      res_status_reg, res_status_next;
    entry_t          res_top_reg, res_top_next;
    logic            m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic            accept;
    logic            in_op;
    entry_t          in_entry;
    entry_t          last_e;
    logic [CW+3:0]   cnt_ext;
    logic            peek_state;

    token_t          tok_in_a  [LEVELS];
    token_t          tok_out_a [LEVELS];
    logic [NW-1:0]   tin_node  [LEVELS];
    logic [NW-1:0]   tout_node [LEVELS];
    upwrite_t        uw_a      [LEVELS];
    logic [NW-1:0]   uw_node   [LEVELS];
    upwrite_t        uw_in_a   [LEVELS];
    logic [NW-1:0]   uw_in_node[LEVELS];
    entry_t          lo_a      [LEVELS];
    entry_t          hi_a      [LEVELS];
    logic            peek_en   [LEVELS];
    logic [NW-1:0]   peek_node [LEVELS];
    logic [LEVELS-1:0] done_vec;

    // request fields
    assign in_op    = s_tdata[0];
    assign in_entry = '{key: s_tdata[8:1], tiebreak: s_tdata[16:9],
                        payload: s_tdata[32:17]};

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign peek_state = (state_reg == ST_PEEK);

    // chain of level cells
    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        localparam int FIRST = (1 << l) - 1;
        localparam int SIZE  = ((CAPACITY - FIRST) < (1 << l)) ? (CAPACITY - FIRST)
                                                               : (1 << l);
        localparam int ROWS  = (SIZE + 1) / 2;

        if (l == 0) begin : g_head
            assign tok_in_a[l] = (tok_reg.valid && !tok_reg.is_remove) ? tok_reg
                                                                       : TOKEN_NONE;
            assign tin_node[l] = NW'(1);
        end else if (l == 1) begin : g_second
            assign tok_in_a[l] = (tok_reg.valid && tok_reg.is_remove) ? tok_reg
                                                                      : tok_out_a[0];
            assign tin_node[l] = (tok_reg.valid && tok_reg.is_remove) ? NW'(1)
                                                                      : tout_node[0];
        end else begin : g_mid
            assign tok_in_a[l] = tok_out_a[l-1];
            assign tin_node[l] = tout_node[l-1];
        end

        if (l < LEVELS - 1) begin : g_below
            assign uw_in_a[l]    = uw_a[l+1];
            assign uw_in_node[l] = uw_node[l+1];
        end else begin : g_bottom
            assign uw_in_a[l]    = UPWRITE_NONE;
            assign uw_in_node[l] = '0;
        end

        assign peek_en[l]   = peek_state && ((l == 0) || (lt_reg == LW'(l)));
        assign peek_node[l] = (l == 0) ? NW'(1) : node_reg;

        mhpq_cell #(
            .LEVEL (l),
            .ROWS  (ROWS),
            .CW    (CW),
            .LW    (LW)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .count        (count_reg),
            .lt           (lt_reg),
            .peek_en      (peek_en[l]),
            .peek_node    (peek_node[l]),
            .tok_in       (tok_in_a[l]),
            .tok_in_node  (tin_node[l]),
            .tok_out      (tok_out_a[l]),
            .tok_out_node (tout_node[l]),
            .uw_in        (uw_in_a[l]),
            .uw_in_node   (uw_in_node[l]),
            .uw_out       (uw_a[l]),
            .uw_out_node  (uw_node[l]),
            .rd_lo        (lo_a[l]),
            .rd_hi        (hi_a[l]),
            .done         (done_vec[l])
        );
    end

    // last entry of the heap, from the level it sits in
    assign last_e = (node_reg[0] && (lt_reg != '0)) ? hi_a[lt_reg] : lo_a[lt_reg];

    assign cnt_ext = {4'b0000, count_reg};

    // request sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        lt_next         = lt_reg;
        node_next       = node_reg;
        tok_next        = TOKEN_NONE;
        res_status_next = res_status_reg;
        res_top_next    = res_top_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_top_next    = '0;
                    res_status_next = STATUS_OK;
                    if (in_op == OP_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_FIN;
                        end else begin
                            count_next       = count_reg + CW'(1);
                            lt_next          = node_level(count_reg + CW'(1));
                            tok_next.valid   = 1'b1;
                            tok_next.carried = in_entry;
                            state_next       = ST_WALK;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_FIN;
                        end else begin
                            count_next = count_reg - CW'(1);
                            lt_next    = node_level(count_reg);
                            node_next  = {1'b0, count_reg};
                            state_next = ST_PEEK;
                        end
                    end
                end
            end
            ST_PEEK: begin
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                res_top_next = lo_a[0];
                if (count_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    tok_next.valid     = 1'b1;
                    tok_next.is_remove = 1'b1;
                    tok_next.carried   = last_e;
                    state_next         = ST_WALK;
                end
            end
            ST_WALK: begin
                if (|done_vec) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, cnt_ext[3:0], res_top_reg.payload,
                                    res_top_reg.tiebreak, res_top_reg.key,
                                    res_status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tok_reg     <= TOKEN_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tok_reg     <= tok_next;
            m_valid_reg <= m_valid_next;
        end
        lt_reg         <= lt_next;
        node_reg       <= node_next;
        res_status_reg <= res_status_next;
        res_top_reg    <= res_top_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // entry count never passes the capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // only one level finishes a walk
    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("more than one level cell reported done");

    // a launched token always belongs to a walk
    a_token_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.valid |-> (state_reg == ST_WALK))
        else $error("token launched outside a walk");

    // rejected requests carry no entry
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != STATUS_OK)) |-> (m_tdata[33:2] == '0))
        else $error("rejected request returned entry data");
`endif

endmodule

`default_nettype wire
